@@ src/brd_pkg.sv @@
// Package for the binary to radix digit converter.
// Holds the widths, the base limits, the sequencer states and the structs between modules.
// No dependencies.
package brd_pkg;

   localparam int VALUE_BITS    = 16;
   localparam int CELL_COUNT    = VALUE_BITS;
   localparam int IDX_BITS      = $clog2(VALUE_BITS);

   localparam int IN_VALUE_BITS = 16;
   localparam int BASE_BITS     = 4;
   localparam int DIGIT_BITS    = 4;
   localparam int ACC_BITS      = 50;
   localparam int COUNT_BITS    = 5;
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 56;

   localparam logic [BASE_BITS-1:0] BASE_MIN = 4'd2;
   localparam logic [BASE_BITS-1:0] BASE_MAX = 4'd10;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FEED,
      ST_DRAIN,
      ST_READ,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic                  tok;
      logic                  carry;
      logic [DIGIT_BITS-1:0] digit;
   } link_type;

   typedef struct packed {
      logic clear;
      logic shift;
   } cell_cmd_type;

   typedef struct packed {
      logic                clear;
      logic                take;
      logic [IDX_BITS-1:0] index;
   } acc_cmd_type;

endpackage

@@ src/brd_cell.sv @@
// One digit cell of the conversion row: doubles its base-b digit and adds the incoming carry.
// Depends on brd_pkg for the link and command structs.
module brd_cell import brd_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cell_cmd_type         cmd,
   input  logic [BASE_BITS-1:0] base,
   input  link_type             link_i,
   output link_type             link_o
);

   logic [DIGIT_BITS-1:0] digit_ff, digit_in;
   logic                  tok_ff, tok_in;
   logic                  carry_ff, carry_in;
   logic [DIGIT_BITS:0]   dbl;
   logic [DIGIT_BITS:0]   base_ext;

   always_comb begin
      dbl      = {digit_ff, link_i.carry};
      base_ext = {1'b0, base};
      digit_in = digit_ff;
      tok_in   = 1'b0;
      carry_in = 1'b0;
      priority if (cmd.clear) begin
         digit_in = '0;
      end else if (cmd.shift) begin
         digit_in = link_i.digit;
      end else if (link_i.tok) begin
         tok_in = 1'b1;
         if (dbl >= base_ext) begin
            digit_in = DIGIT_BITS'(dbl - base_ext);
            carry_in = 1'b1;
         end else begin
            digit_in = DIGIT_BITS'(dbl);
         end
      end else begin
         digit_in = digit_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_ff   <= 1'b0;
         carry_ff <= 1'b0;
      end else begin
         tok_ff   <= tok_in;
         carry_ff <= carry_in;
      end
   end

   always_ff @(posedge clock) begin
      digit_ff <= digit_in;
   end

   assign link_o.tok   = tok_ff;
   assign link_o.carry = carry_ff;
   assign link_o.digit = digit_ff;

endmodule

@@ src/brd_accum.sv @@
// Decimal accumulator: builds the decimal-coded result from digits read most significant first.
// Also finds the digit count from the first nonzero digit. Depends on brd_pkg.
module brd_accum import brd_pkg::*; (
   input  logic                  clock,
   input  acc_cmd_type           cmd,
   input  logic [DIGIT_BITS-1:0] digit_i,
   output logic [ACC_BITS-1:0]   acc_o,
   output logic [COUNT_BITS-1:0] count_o
);

   logic [ACC_BITS-1:0]   acc_ff, acc_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      acc_in   = acc_ff;
      count_in = count_ff;
      if (cmd.clear) begin
         acc_in   = '0;
         count_in = '0;
      end else if (cmd.take) begin
         acc_in = (acc_ff << 3) + (acc_ff << 1) + ACC_BITS'(digit_i);
         if (count_ff == '0 && digit_i != '0) begin
            count_in = COUNT_BITS'(CELL_COUNT) - COUNT_BITS'(cmd.index);
         end
      end
   end

   always_ff @(posedge clock) begin
      acc_ff   <= acc_in;
      count_ff <= count_in;
   end

   assign acc_o   = acc_ff;
   assign count_o = count_ff;

endmodule

@@ src/brd_ctrl.sv @@
// Sequencer of the converter: takes a word, feeds its bits into the cell row, waits for the
// carry wave to pass and then reads the digits out. Depends on brd_pkg.
module brd_ctrl import brd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [IN_VALUE_BITS-1:0] value_i,
   input  logic [BASE_BITS-1:0]     base_i,
   input  logic                     rsp_busy,
   input  logic                     top_tok,
   output cell_cmd_type             cell_cmd,
   output link_type                 link0,
   output logic [BASE_BITS-1:0]     base_o,
   output acc_cmd_type              acc_cmd,
   output logic                     bad_o,
   output logic                     load_o
);

   localparam logic [IDX_BITS-1:0] LAST_FEED  = IDX_BITS'(VALUE_BITS - 1);
   localparam logic [IDX_BITS-1:0] LAST_DRAIN = IDX_BITS'(CELL_COUNT - 2);
   localparam logic [IDX_BITS-1:0] LAST_READ  = IDX_BITS'(CELL_COUNT - 1);

   state_type              state_ff, state_in;
   logic [IDX_BITS-1:0]    cnt_ff, cnt_in;
   logic [VALUE_BITS-1:0]  value_ff, value_in;
   logic [BASE_BITS-1:0]   base_ff, base_in;
   logic                   bad_ff, bad_in;
   logic                   base_bad;
   logic                   accept;

   assign base_bad = (base_i < BASE_MIN) || (base_i > BASE_MAX);
   assign accept   = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      value_in = value_ff;
      base_in  = base_ff;
      bad_in   = bad_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               value_in = VALUE_BITS'(value_i);
               base_in  = base_i;
               bad_in   = base_bad;
               cnt_in   = '0;
               state_in = base_bad ? ST_DONE : ST_FEED;
            end
         end
         ST_FEED: begin
            value_in = value_ff << 1;
            if (cnt_ff == LAST_FEED) begin
               cnt_in   = '0;
               state_in = ST_DRAIN;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DRAIN: begin
            if (cnt_ff == LAST_DRAIN) begin
               cnt_in   = '0;
               state_in = ST_READ;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_READ: begin
            if (cnt_ff == LAST_READ) begin
               cnt_in   = '0;
               state_in = ST_DONE;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_tready     = (state_ff == ST_IDLE);
      cell_cmd.clear = accept;
      cell_cmd.shift = (state_ff == ST_READ);
      link0.tok      = (state_ff == ST_FEED);
      link0.carry    = value_ff[VALUE_BITS-1];
      link0.digit    = '0;
      acc_cmd.clear  = accept;
      acc_cmd.take   = (state_ff == ST_READ);
      acc_cmd.index  = cnt_ff;
      load_o         = (state_ff == ST_DONE) && !rsp_busy;
      bad_o          = bad_ff;
      base_o         = base_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      base_ff  <= base_in;
      bad_ff   <= bad_in;
   end

   // The last bit reaches the top cell exactly as the drain phase ends.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DRAIN && cnt_ff == LAST_DRAIN) |=> top_tok)
      else $error("last bit did not reach the top cell at the end of the drain phase");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_READ && cnt_ff != '0) |-> !top_tok)
      else $error("top cell still stepping during readout");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FEED) |-> !bad_ff)
      else $error("word with an invalid base entered the cell row");

endmodule

@@ src/binary_to_radix_digits.sv @@
// Top level of the binary to radix digit converter: stream ports, cell row, output register.
// Depends on brd_pkg, brd_cell, brd_accum and brd_ctrl.
//
// Converts a 16-bit unsigned word to base 2 to 10 and returns the digits written as decimal
// digits of one integer, most significant first, together with the digit count. One word is
// in work at a time. A word with a valid base has its bits shifted, most significant first,
// into a row of VALUE_BITS digit cells; then the carry wave passes on to the last cell, the
// digits are shifted out through the decimal accumulator, and the output register is loaded.
// A word with a base outside 2 to 10 gives a zero result with the error flag in tuser. A new
// word is taken as soon as the previous result sits in the output register, even while that
// result still waits.
module binary_to_radix_digits import brd_pkg::*; (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   // Fields from bit 0: value (16), target_base (4), zero fill (4).
   input  logic [REQ_DATA_BITS-1:0] req_tdata,
   output logic                     rsp_tvalid,
   input  logic                     rsp_tready,
   // Fields from bit 0: digits_as_decimal (50), digit_count (5), zero fill (1).
   output logic [RSP_DATA_BITS-1:0] rsp_tdata,
   // Fields from bit 0: bad_base (1).
   output logic                     rsp_tuser
);

   link_type              link [0:CELL_COUNT];
   cell_cmd_type          cell_cmd;
   acc_cmd_type           acc_cmd;
   logic [BASE_BITS-1:0]  base;
   logic                  bad;
   logic                  load;
   logic                  rsp_busy;
   logic [ACC_BITS-1:0]   acc;
   logic [COUNT_BITS-1:0] count;

   logic                  rsp_valid_ff, rsp_valid_in;
   logic [ACC_BITS-1:0]   rsp_digits_ff;
   logic [COUNT_BITS-1:0] rsp_count_ff;
   logic                  rsp_bad_ff;

   assign rsp_busy = rsp_valid_ff && !rsp_tready;

   brd_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .value_i    (req_tdata[IN_VALUE_BITS-1:0]),
      .base_i     (req_tdata[IN_VALUE_BITS +: BASE_BITS]),
      .rsp_busy   (rsp_busy),
      .top_tok    (link[CELL_COUNT].tok),
      .cell_cmd   (cell_cmd),
      .link0      (link[0]),
      .base_o     (base),
      .acc_cmd    (acc_cmd),
      .bad_o      (bad),
      .load_o     (load)
   );

   for (genvar k = 0; k < CELL_COUNT; k++) begin : g_cell
      brd_cell u_cell (
         .clock  (clock),
         .reset  (reset),
         .cmd    (cell_cmd),
         .base   (base),
         .link_i (link[k]),
         .link_o (link[k+1])
      );
   end

   brd_accum u_accum (
      .clock   (clock),
      .cmd     (acc_cmd),
      .digit_i (link[CELL_COUNT].digit),
      .acc_o   (acc),
      .count_o (count)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_digits_ff <= acc;
         rsp_count_ff  <= count;
         rsp_bad_ff    <= bad;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = RSP_DATA_BITS'({rsp_count_ff, rsp_digits_ff});
   assign rsp_tuser  = rsp_bad_ff;

   // The row is as long as the widest base-2 result, so no carry ever leaves it.
   assert property (@(posedge clock) disable iff (reset)
      !link[CELL_COUNT].carry)
      else $error("carry left the top digit cell");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_bad_ff) |-> (rsp_digits_ff == '0 && rsp_count_ff == '0))
      else $error("invalid base word carries a nonzero result");

   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_count_ff == '0) |-> (rsp_digits_ff == '0))
      else $error("nonzero digits with a zero digit count");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_count_ff <= COUNT_BITS'(CELL_COUNT)))
      else $error("digit count exceeds the number of cells");

endmodule

@@ tb/sv/binary_to_radix_digits_test.sv @@
`timescale 1ns / 1ps
// Self-checking testbench for binary_to_radix_digits: directed and random words, random gaps
// and stalls on both streams, every result checked against an in-bench radix converter.
// Depends on brd_pkg and the binary_to_radix_digits RTL.
module binary_to_radix_digits_test;
   import brd_pkg::*;

   typedef struct {
      logic [IN_VALUE_BITS-1:0] value;
      logic [BASE_BITS-1:0]     base;
      bit                       drain;
   } conv_word_type;

   typedef struct {
      logic [ACC_BITS-1:0]   digits;
      logic [COUNT_BITS-1:0] count;
      logic                  bad_base;
   } radix_result_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     rsp_tuser;

   conv_word_type    pending_words[$];
   radix_result_type expected_results[$];
   int               mismatch_count = 0;
   int               accepted_words = 0;
   bit               req_taken = 1'b0;
   bit               calm = 1'b0;
   int               req_gap = 0;
   int               rsp_stall = 0;

   binary_to_radix_digits u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #1 clock = ~clock;

   function automatic radix_result_type convert_to_radix(logic [IN_VALUE_BITS-1:0] value,
                                                         logic [BASE_BITS-1:0] base);
      radix_result_type r;
      logic [63:0]      rest;
      logic [63:0]      place;
      logic [63:0]      acc;
      logic [63:0]      radix;
      int               i;
      r.digits   = '0;
      r.count    = '0;
      r.bad_base = 1'b0;
      if (base < BASE_MIN || base > BASE_MAX) begin
         r.bad_base = 1'b1;
         return r;
      end
      rest  = 64'(value) & ((64'd1 << VALUE_BITS) - 64'd1);
      radix = 64'(base);
      place = 64'd1;
      acc   = 64'd0;
      for (i = 0; i < VALUE_BITS && rest != 0; i++) begin
         acc   = acc + (rest % radix) * place;
         place = place * 64'd10;
         rest  = rest / radix;
         r.count = r.count + 1'b1;
      end
      r.digits = acc[ACC_BITS-1:0];
      return r;
   endfunction

   function automatic int pick_gap(bit quiet);
      int r;
      r = $urandom_range(0, 15);
      if (quiet || r < 8) return 0;
      if (r < 14) return $urandom_range(1, 3);
      return $urandom_range(4, 30);
   endfunction

   function automatic logic [IN_VALUE_BITS-1:0] random_value();
      case ($urandom_range(0, 4))
         0: return IN_VALUE_BITS'($urandom_range(0, 15));
         1: return 16'h1 << $urandom_range(0, 15);
         2: return 16'hFFFF >> $urandom_range(0, 15);
         default: return IN_VALUE_BITS'($urandom());
      endcase
   endfunction

   task automatic add_word(logic [IN_VALUE_BITS-1:0] value, logic [BASE_BITS-1:0] base,
                           bit drain);
      conv_word_type w;
      w.value = value;
      w.base  = base;
      w.drain = drain;
      pending_words.push_back(w);
   endtask

   task automatic note_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatch_count++;
   endtask

   // Sender: holds a word until it is taken, then waits out a random gap.
   always @(negedge clock) begin
      logic          next_valid;
      conv_word_type w;
      next_valid = req_tvalid && !req_taken;
      if (reset) begin
         next_valid = 1'b0;
      end else if (!next_valid) begin
         if (req_taken) begin
            req_gap = pick_gap(calm);
         end
         if (req_gap > 0) begin
            req_gap--;
         end else if (pending_words.size() != 0 &&
                      (!pending_words[0].drain || expected_results.size() == 0)) begin
            w = pending_words.pop_front();
            req_tdata <= {4'b0000, w.base, w.value};
            next_valid = 1'b1;
         end
      end
      req_tvalid <= next_valid;
   end

   // Receiver: random stalls on the result stream.
   always @(negedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (rsp_stall > 0) begin
         rsp_stall--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
         if ($urandom_range(0, 3) == 0) begin
            rsp_stall = pick_gap(calm);
         end
      end
   end

   always @(posedge clock) begin
      radix_result_type want;
      req_taken = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            req_taken = 1'b1;
            expected_results.push_back(convert_to_radix(req_tdata[15:0], req_tdata[19:16]));
            accepted_words++;
            if (accepted_words % 64 == 0) begin
               calm = ($urandom_range(0, 3) == 0);
            end
         end
         if (rsp_tvalid && rsp_tready) begin
            if (expected_results.size() == 0) begin
               note_mismatch("result word with nothing expected");
            end else begin
               want = expected_results.pop_front();
               if (rsp_tdata[49:0] !== want.digits) begin
                  note_mismatch($sformatf("digits got %0d expected %0d",
                                          rsp_tdata[49:0], want.digits));
               end
               if (rsp_tdata[54:50] !== want.count) begin
                  note_mismatch($sformatf("digit count got %0d expected %0d",
                                          rsp_tdata[54:50], want.count));
               end
               if (rsp_tuser !== want.bad_base) begin
                  note_mismatch($sformatf("bad base flag got %b expected %b",
                                          rsp_tuser, want.bad_base));
               end
            end
         end
      end
   end

   initial begin
      int b;
      int n;
      // All ones through every base, legal or not.
      for (b = 0; b < 16; b++) begin
         add_word(16'hFFFF, b[3:0], 1'b0);
      end
      add_word(16'h0000, 4'd2, 1'b0);
      add_word(16'h0000, 4'd10, 1'b0);
      add_word(16'h0000, 4'd0, 1'b0);
      add_word(16'h0001, 4'd7, 1'b0);
      add_word(16'hAAAA, 4'd2, 1'b0);
      add_word(16'h5555, 4'd9, 1'b0);
      add_word(16'h0008, 4'd8, 1'b0);
      add_word(16'd100, 4'd10, 1'b0);
      for (n = 0; n < 850; n++) begin
         if ($urandom_range(0, 4) == 0) begin
            add_word(random_value(), BASE_BITS'($urandom_range(0, 15)),
                     n == 0 || $urandom_range(0, 99) == 0);
         end else begin
            add_word(random_value(), BASE_BITS'($urandom_range(2, 10)),
                     n == 0 || $urandom_range(0, 99) == 0);
         end
      end

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (pending_words.size() != 0 || req_tvalid || expected_results.size() != 0) begin
         @(posedge clock);
      end
      repeat (120) @(posedge clock);
      if (expected_results.size() != 0) begin
         note_mismatch($sformatf("%0d results never arrived", expected_results.size()));
      end
      if (mismatch_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   initial begin
      #1000000;
      $display("== FAIL ==");
      $finish;
   end

endmodule
